[rtl/divider_and_reload_timer_unit_assert.svh]
// Assertion macros shared by the divider and reload timer RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DIVIDER_AND_RELOAD_TIMER_UNIT_ASSERT_SVH
`define DIVIDER_AND_RELOAD_TIMER_UNIT_ASSERT_SVH

// Condition that holds at every clock edge out of reset.
`define DRT_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Same-cycle implication.
`define DRT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/drt_pkg.sv]
// Package for the divider and reload timer: item types, codes, period decode.
// No dependencies.
package drt_pkg;

  localparam int unsigned CounterBitsDef = 16;

  // Item mode codes
  localparam logic [1:0] ModeTick  = 2'd0;
  localparam logic [1:0] ModeRead  = 2'd1;
  localparam logic [1:0] ModeWrite = 2'd2;

  // Register select codes
  localparam logic [1:0] RegDiv  = 2'd0;
  localparam logic [1:0] RegTima = 2'd1;
  localparam logic [1:0] RegTma  = 2'd2;
  localparam logic [1:0] RegTac  = 2'd3;

  // Highest counter residue modulo 255; the divider steps when the residue returns to zero
  localparam logic [7:0] DivPeriodLast = 8'd254;

  localparam int unsigned TacEnableBit = 2;

  localparam logic [1:0] PeriodSel1024 = 2'd0;
  localparam logic [1:0] PeriodSel16   = 2'd1;
  localparam logic [1:0] PeriodSel64   = 2'd2;
  localparam logic [1:0] PeriodSel256  = 2'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] reg_select;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       timer_irq;
  } out_item_t;

  // True when the low counter bits are a multiple of the selected period.
  function automatic logic period_hit(logic [9:0] low, logic [1:0] sel);
    logic hit;
    unique case (sel)
      PeriodSel1024: hit = (low[9:0] == 10'd0);
      PeriodSel16:   hit = (low[3:0] == 4'd0);
      PeriodSel64:   hit = (low[5:0] == 6'd0);
      PeriodSel256:  hit = (low[7:0] == 8'd0);
      default:       hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[rtl/drt_core.sv]
// Timer state and per-item update logic: counter, divider, timer count, reload, control.
// Depends on drt_pkg and the assertion macro header.
`include "divider_and_reload_timer_unit_assert.svh"

module drt_core #(
  parameter int unsigned CounterBits = drt_pkg::CounterBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  drt_pkg::in_item_t  item_i,
  output drt_pkg::out_item_t result_o
);
  import drt_pkg::*;

  logic [CounterBits-1:0] cnt_q, cnt_d;
  logic [7:0] res_q, res_d;   // counter value modulo 255
  logic [7:0] div_q, div_d;
  logic [7:0] tima_q, tima_d;
  logic [7:0] tma_q, tma_d;
  logic [7:0] tac_q, tac_d;

  logic [CounterBits-1:0] cnt_inc;
  logic [7:0] res_inc;
  logic       div_hit;
  logic       timer_hit;
  logic       ovf;
  logic [7:0] sel_data;

  // Residue tracks the counter mod 255; on wrap the counter becomes zero.
  always_comb begin
    cnt_inc = cnt_q + {{(CounterBits-1){1'b0}}, 1'b1};
    if (&cnt_q || res_q == DivPeriodLast) begin
      res_inc = 8'd0;
    end else begin
      res_inc = res_q + 8'd1;
    end
    div_hit   = (res_inc == 8'd0);
    timer_hit = tac_q[TacEnableBit] && period_hit(cnt_inc[9:0], tac_q[1:0]);
    ovf       = timer_hit && (tima_q == 8'hFF);
  end

  always_comb begin
    unique case (item_i.reg_select)
      RegDiv:  sel_data = div_q;
      RegTima: sel_data = tima_q;
      RegTma:  sel_data = tma_q;
      RegTac:  sel_data = tac_q;
      default: sel_data = 8'd0;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    res_d  = res_q;
    div_d  = div_q;
    tima_d = tima_q;
    tma_d  = tma_q;
    tac_d  = tac_q;
    result_o = '0;
    unique case (item_i.mode)
      ModeTick: begin
        cnt_d = cnt_inc;
        res_d = res_inc;
        if (div_hit) begin
          div_d = div_q + 8'd1;
        end
        if (ovf) begin
          tima_d = tma_q;
        end else if (timer_hit) begin
          tima_d = tima_q + 8'd1;
        end
        result_o.timer_irq = ovf;
      end
      ModeRead: begin
        result_o.read_data = sel_data;
      end
      ModeWrite: begin
        unique case (item_i.reg_select)
          RegDiv:  div_d  = item_i.write_data;
          RegTima: tima_d = item_i.write_data;
          RegTma:  tma_d  = item_i.write_data;
          RegTac:  tac_d  = item_i.write_data;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      res_q  <= '0;
      div_q  <= '0;
      tima_q <= '0;
      tma_q  <= '0;
      tac_q  <= '0;
    end else if (en_i) begin
      cnt_q  <= cnt_d;
      res_q  <= res_d;
      div_q  <= div_d;
      tima_q <= tima_d;
      tma_q  <= tma_d;
      tac_q  <= tac_d;
    end
  end

  `DRT_ASSERT_ALWAYS(a_res_range, res_q != 8'hFF, "residue out of range")
  `DRT_ASSERT_IMPL(a_res_wrap, cnt_q == '0, res_q == 8'd0, "residue not zero at counter zero")
  `DRT_ASSERT_IMPL(a_irq_tick, result_o.timer_irq, item_i.mode == ModeTick, "irq off a tick")
  `DRT_ASSERT_IMPL(a_irq_en, result_o.timer_irq, tac_q[TacEnableBit], "irq while disabled")
  `DRT_ASSERT_IMPL(a_rd_read, result_o.read_data != '0, item_i.mode == ModeRead, "stray read data")

endmodule

[rtl/divider_and_reload_timer_unit.sv]
// Top level of the divider and reload timer: input register, core, result register.
// Depends on drt_pkg, drt_core and the assertion macro header.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid_i / in_stall_o
//   out     | output    | out_item_t | out_valid_o / out_stall_i
//
// One item per cycle sustained while the output is not stalled; an accepted item waits in the
// input register, the core processes it and its result is captured in the result register.
// Reset clears the counter, divider, timer count, reload value and control.
// A stall on the output holds the result register and backs up into the input
// register; the input stalls only when both are full and the output is stalled.
`include "divider_and_reload_timer_unit_assert.svh"

module divider_and_reload_timer_unit #(
  parameter int unsigned CounterBits = drt_pkg::CounterBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drt_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drt_pkg::out_item_t out_item_o
);
  import drt_pkg::*;

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  out_item_t result;
  logic      advance;
  logic      fire;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  drt_core #(
    .CounterBits(CounterBits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (fire),
    .item_i  (in_item_q),
    .result_o(result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (fire) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `DRT_ASSERT_NEXT(a_fire_out, fire, out_valid_q, "processed item has no result")
  `DRT_ASSERT_IMPL(a_stall_full, in_stall_o, in_valid_q && out_valid_q, "stall with free space")

endmodule
